FILE: rtl/csh_pkg.sv
package csh_pkg;

    localparam int unsigned StateWords  = 24;
    localparam int unsigned RateWords   = 15;
    localparam int unsigned DigestWords = 8;
    localparam int unsigned WordW       = 64;
    localparam int unsigned VbitsW      = 7;
    localparam int unsigned DefRounds   = 18;
    localparam int unsigned InvOffset   = 9;
    localparam logic [63:0] RcLo        = 64'h1319_8A2E_0370_7344;
    localparam logic [63:0] RcHi        = 64'h243F_6A88_85A3_08D3;
    localparam logic [63:0] Lane16      = 64'h0001_0001_0001_0001;

    typedef logic [63:0] t_word;
    typedef t_word [StateWords-1:0] t_state;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_PERM,
        ST_FINAL,
        ST_OUT
    } t_fsm;

    typedef struct packed {
        logic absorb;
        logic pad;
        logic perm_start;
        logic perm_step;
        logic perm_end;
        logic clear;
    } t_cmd;

    function automatic t_word ror16(t_word x, int unsigned n);
        t_word r;
        for (int l = 0; l < 4; l++) begin
            r[l*16 +: 16] = (x[l*16 +: 16] >> n) | (x[l*16 +: 16] << ((16 - n) % 16));
        end
        return r;
    endfunction

    function automatic t_state mand_rx(t_state s, int unsigned lrow, int unsigned rrow,
                                       int unsigned a, int unsigned b, int unsigned g);
        t_state o;
        t_word x;
        o = s;
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 4; k++) begin
                x = s[(lrow + i) * 4 + k];
                o[(rrow + i) * 4 + k] = s[(rrow + i) * 4 + k]
                    ^ ror16(x, g) ^ (ror16(x, b) & ror16(x, a));
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] rot_lane(logic [127:0] w, int unsigned nb);
        return (w >> (nb * 8)) | (w << ((128 - nb * 8) % 128));
    endfunction

    function automatic t_state shift_rows(t_state s, int unsigned lrow, int unsigned rrow);
        t_state o;
        int unsigned shl_lo [3];
        int unsigned shl_hi [3];
        int unsigned shr_lo [3];
        int unsigned shr_hi [3];
        shl_lo = '{0, 4, 8};
        shl_hi = '{2, 6, 10};
        shr_lo = '{0, 12, 8};
        shr_hi = '{14, 10, 6};
        o = s;
        for (int i = 0; i < 3; i++) begin
            {o[(lrow+i)*4+1], o[(lrow+i)*4]} =
                rot_lane({s[(lrow+i)*4+1], s[(lrow+i)*4]}, shl_lo[i]);
            {o[(lrow+i)*4+3], o[(lrow+i)*4+2]} =
                rot_lane({s[(lrow+i)*4+3], s[(lrow+i)*4+2]}, shl_hi[i]);
            {o[(rrow+i)*4+1], o[(rrow+i)*4]} =
                rot_lane({s[(rrow+i)*4+1], s[(rrow+i)*4]}, shr_lo[i]);
            {o[(rrow+i)*4+3], o[(rrow+i)*4+2]} =
                rot_lane({s[(rrow+i)*4+3], s[(rrow+i)*4+2]}, shr_hi[i]);
        end
        return o;
    endfunction

    function automatic t_state mix_rows(t_state s);
        t_state o;
        logic [31:0] e [4];
        for (int l = 0; l < 12; l++) begin
            e[0] = s[2*l][31:0];
            e[1] = s[2*l][63:32];
            e[2] = s[2*l+1][31:0];
            e[3] = s[2*l+1][63:32];
            o[2*l]   = {e[1] ^ e[2] ^ e[0], e[0] ^ e[1] ^ e[3]};
            o[2*l+1] = {e[3] ^ e[0] ^ e[2], e[2] ^ e[3] ^ e[1]};
        end
        return o;
    endfunction

    function automatic t_state swap_rows(t_state s);
        t_state o;
        o = s;
        for (int r = 3; r < 6; r++) begin
            o[r*4]   = s[r*4+2];
            o[r*4+1] = s[r*4+3];
            o[r*4+2] = s[r*4];
            o[r*4+3] = s[r*4+1];
        end
        return o;
    endfunction

    function automatic t_state cross_mix(t_state s);
        t_state o;
        for (int r = 0; r < 6; r++) begin
            for (int k = 0; k < 4; k++) begin
                o[r*4+k] = s[r*4+k] ^ s[((r+1)%6)*4+k] ^ s[((r+4)%6)*4+k];
            end
        end
        return o;
    endfunction

    function automatic t_state mix_columns(t_state s);
        t_state o;
        for (int k = 0; k < 4; k++) begin
            o[k]    = s[4+k] ^ s[8+k];
            o[4+k]  = s[k] ^ s[8+k];
            o[8+k]  = s[k] ^ s[4+k] ^ s[8+k];
            o[12+k] = s[12+k] ^ s[20+k];
            o[16+k] = s[16+k] ^ s[20+k];
            o[20+k] = s[12+k] ^ s[16+k] ^ s[20+k];
        end
        return o;
    endfunction

    function automatic t_state add_constant(t_state s, logic [15:0] rn);
        t_state o;
        t_word x;
        x = {rn, rn, rn, rn};
        o = s;
        o[0] = s[0] ^ RcLo ^ x;
        o[1] = s[1] ^ RcHi ^ x;
        return o;
    endfunction

    function automatic t_state fwd_round(t_state s, logic [15:0] rn);
        t_state t;
        t = swap_rows(cross_mix(s));
        t = mand_rx(t, 0, 3, 0, 1, 8);
        t = mand_rx(t, 3, 0, 14, 5, 0);
        t = mand_rx(t, 0, 3, 9, 12, 8);
        t = mand_rx(t, 3, 0, 14, 5, 0);
        t = mand_rx(t, 0, 3, 0, 1, 8);
        t = mand_rx(t, 3, 0, 8, 9, 0);
        t = mix_columns(swap_rows(cross_mix(t)));
        t = mix_rows(shift_rows(t, 0, 3));
        return add_constant(t, rn);
    endfunction

    function automatic t_state inv_round(t_state s, logic [15:0] rn);
        t_state t;
        t_state u;
        t = mix_rows(add_constant(s, rn));
        t = cross_mix(swap_rows(mix_columns(shift_rows(t, 3, 0))));
        t = mand_rx(t, 3, 0, 8, 9, 0);
        t = mand_rx(t, 0, 3, 0, 1, 8);
        t = mand_rx(t, 3, 0, 14, 5, 0);
        t = mand_rx(t, 0, 3, 9, 12, 8);
        t = mand_rx(t, 3, 0, 14, 5, 0);
        t = mand_rx(t, 0, 3, 0, 1, 8);
        for (int j = 0; j < 12; j++) begin
            u[j]      = t[j+12];
            u[j+12]   = t[j];
        end
        return cross_mix(swap_rows(u));
    endfunction

endpackage

FILE: rtl/csh_if.sv
interface csh_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] msg_word;
    logic [6:0]  valid_bits;
    logic        last_word;
    modport source (output valid, msg_word, valid_bits, last_word, input ready);
    modport sink (input valid, msg_word, valid_bits, last_word, output ready);
endinterface

interface csh_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic        digest_last;
    modport source (output valid, digest_word, digest_last, input ready);
    modport sink (input valid, digest_word, digest_last, output ready);
endinterface

FILE: rtl/cube_sponge_hash_512.sv
// Sponge hash with a 1536-bit state and a 512-bit digest.
// Input channel: 64-bit message words, first byte in bits 7..0, with a count
// of valid bits and a flag on the last word of a message.
// Output channel: eight 64-bit digest words, the eighth marked as last.
// A beat that is not the last is absorbed when it is accepted. Every fifteenth
// word starts a permutation, one round per cycle on a forward and an inverse
// datapath side by side, plus a load step and a combining step.
// The last word costs a padding step and one permutation (two when it fills its
// block); the digest beats then follow one per cycle while the sink is ready.
// Input is not taken while a permutation runs or the digest is read out.
// A stalled receiver holds the current digest beat; nothing is lost.
// Reset clears the state and control; the block is then ready for a message.
module cube_sponge_hash_512
    import csh_pkg::*;
#(
    parameter int unsigned ROUNDS = DefRounds
) (
    input  logic i_clk,
    input  logic i_rst_n,
    csh_in_if.sink    i_in,
    csh_out_if.source o_out
);
    localparam int unsigned RW = $clog2(ROUNDS / 2 + 1);

    t_cmd          w_cmd;
    logic          w_full;
    logic [3:0]    w_pos;
    logic [RW-1:0] w_rnd;
    logic [2:0]    w_idx;
    logic          w_ready;
    logic          w_valid;
    logic          w_last;
    logic [63:0]   w_dig;

    csh_ctrl #(.ROUNDS(ROUNDS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid), .i_last_word(i_in.last_word),
        .i_block_full(w_full), .i_out_ready(o_out.ready),
        .o_in_ready(w_ready), .o_out_valid(w_valid), .o_out_last(w_last),
        .o_cmd(w_cmd), .o_pos(w_pos), .o_round(w_rnd), .o_out_idx(w_idx)
    );

    csh_datapath #(.ROUNDS(ROUNDS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_msg_word(i_in.msg_word), .i_valid_bits(i_in.valid_bits),
        .i_last_word(i_in.last_word), .i_pos(w_pos), .i_round(w_rnd),
        .i_out_idx(w_idx), .o_block_full(w_full), .o_digest_word(w_dig)
    );

    assign i_in.ready = w_ready;
    assign o_out.valid = w_valid;
    assign o_out.digest_word = w_dig;
    assign o_out.digest_last = w_last;
endmodule

FILE: rtl/csh_datapath.sv
module csh_datapath
    import csh_pkg::*;
#(
    parameter int unsigned ROUNDS = DefRounds
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [63:0] i_msg_word,
    input  logic [6:0]  i_valid_bits,
    input  logic        i_last_word,
    input  logic [3:0]  i_pos,
    input  logic [$clog2(ROUNDS/2+1)-1:0] i_round,
    input  logic [2:0]  i_out_idx,
    output logic        o_block_full,
    output logic [63:0] o_digest_word
);
    localparam int unsigned Half = ROUNDS / 2;

    t_state r_fwd, n_fwd;
    t_state r_inv, n_inv;
    logic [5:0] r_off, n_off;   // bit offset of the padding within its word
    t_word  w_masked;
    logic [6:0] w_vsat;
    logic [9:0] w_p;
    t_state w_pad;

    // Masks the last word, flags full or non-last words and forms the padded state.
    always_comb begin
        w_vsat = (i_valid_bits > 7'd64) ? 7'd64 : i_valid_bits;
        w_masked = i_msg_word;
        if (i_last_word && w_vsat < 7'd64) begin
            w_masked = i_msg_word & ((64'd1 << w_vsat[5:0]) - 64'd1);
        end
        o_block_full = !i_last_word || w_vsat == 7'd64;
        w_p = {i_pos, 6'd0} + {4'd0, r_off};
        w_pad = r_fwd;
        w_pad[{1'b0, w_p[9:6]}] = w_pad[{1'b0, w_p[9:6]}] ^ (t_word'(1) << w_p[5:0]);
        if (w_p != 10'd959) begin
            w_pad[RateWords-1][63] = ~w_pad[RateWords-1][63];
        end
    end

    always_comb begin
        n_fwd = r_fwd;
        n_inv = r_inv;
        n_off = r_off;
        if (i_cmd.clear) begin
            n_fwd = '0;
        end else if (i_cmd.absorb) begin
            n_fwd[{1'b0, i_pos}] = r_fwd[{1'b0, i_pos}] ^ w_masked;
            n_off = (w_vsat == 7'd64) ? 6'd0 : w_vsat[5:0];
        end else if (i_cmd.pad) begin
            n_fwd = w_pad;
        end else if (i_cmd.perm_start) begin
            n_inv = r_fwd;
        end else if (i_cmd.perm_step) begin
            n_fwd = fwd_round(r_fwd, 16'(i_round));
            n_inv = inv_round(r_inv, 16'(Half - 1 - i_round + InvOffset));
        end else if (i_cmd.perm_end) begin
            for (int i = 0; i < StateWords; i++) begin
                n_fwd[i] = r_fwd[i] ^ r_inv[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= '0;
            r_inv <= '0;
            r_off <= '0;
        end else begin
            r_fwd <= n_fwd;
            r_inv <= n_inv;
            r_off <= n_off;
        end
    end

    assign o_digest_word = r_fwd[{2'b00, i_out_idx}];
endmodule

FILE: rtl/csh_ctrl.sv
module csh_ctrl
    import csh_pkg::*;
#(
    parameter int unsigned ROUNDS = DefRounds
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_last_word,
    input  logic        i_block_full,
    input  logic        i_out_ready,
    output logic        o_in_ready,
    output logic        o_out_valid,
    output logic        o_out_last,
    output t_cmd        o_cmd,
    output logic [3:0]  o_pos,
    output logic [$clog2(ROUNDS/2+1)-1:0] o_round,
    output logic [2:0]  o_out_idx
);
    localparam int unsigned Half = ROUNDS / 2;
    localparam int unsigned RW = $clog2(Half + 1);

    t_fsm r_st, n_st;
    logic [3:0] r_pos, n_pos;
    logic [RW-1:0] r_rnd, n_rnd;
    logic [2:0] r_idx, n_idx;
    logic r_fin, n_fin;     // the permutation is the final one of a message
    logic r_pad, n_pad;     // padding still to be applied after this permutation
    logic w_acc;

    assign w_acc = i_in_valid && o_in_ready;

    always_comb begin
        n_st = r_st;
        n_pos = r_pos;
        n_rnd = r_rnd;
        n_idx = r_idx;
        n_fin = r_fin;
        n_pad = r_pad;
        case (r_st)
            ST_IDLE: begin
                if (w_acc) begin
                    n_rnd = '0;
                    if (i_last_word) begin
                        if (i_block_full && r_pos == 4'(RateWords - 1)) begin
                            n_pos = '0;
                            n_pad = 1'b1;
                            n_fin = 1'b0;
                            n_st = ST_PERM;
                        end else begin
                            if (i_block_full) begin
                                n_pos = r_pos + 4'd1;
                            end
                            n_st = ST_PAD;
                        end
                    end else if (r_pos == 4'(RateWords - 1)) begin
                        n_pos = '0;
                        n_pad = 1'b0;
                        n_fin = 1'b0;
                        n_st = ST_PERM;
                    end else begin
                        n_pos = r_pos + 4'd1;
                    end
                end
            end
            ST_PAD: begin
                n_fin = 1'b1;
                n_pad = 1'b0;
                n_rnd = '0;
                n_st = ST_PERM;
            end
            ST_PERM: begin
                n_rnd = r_rnd + RW'(1);
                if (r_rnd == RW'(Half)) begin
                    n_st = ST_FINAL;
                end
            end
            ST_FINAL: begin
                n_idx = '0;
                if (r_fin) begin
                    n_st = ST_OUT;
                end else if (r_pad) begin
                    n_st = ST_PAD;
                end else begin
                    n_st = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'(DigestWords - 1)) begin
                        n_pos = '0;
                        n_st = ST_IDLE;
                    end
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    // Round count 0 loads the inverse copy; counts 1..Half run the rounds.
    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_st)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.absorb = i_in_valid;
            end
            ST_PAD: o_cmd.pad = 1'b1;
            ST_PERM: begin
                o_cmd.perm_start = (r_rnd == '0);
                o_cmd.perm_step = (r_rnd != '0);
            end
            ST_FINAL: o_cmd.perm_end = 1'b1;
            ST_OUT: begin
                o_out_valid = 1'b1;
                o_cmd.clear = i_out_ready && r_idx == 3'(DigestWords - 1);
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_pos = r_pos;
    assign o_round = r_rnd - RW'(1);
    assign o_out_idx = r_idx;
    assign o_out_last = (r_idx == 3'(DigestWords - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_pos <= '0;
            r_rnd <= '0;
            r_idx <= '0;
            r_fin <= 1'b0;
            r_pad <= 1'b0;
        end else begin
            r_st <= n_st;
            r_pos <= n_pos;
            r_rnd <= n_rnd;
            r_idx <= n_idx;
            r_fin <= n_fin;
            r_pad <= n_pad;
        end
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < 4'(RateWords)) else $error("word position out of range");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st != ST_IDLE |-> !o_in_ready) else $error("ready while busy");
    a_out_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_OUT && i_out_ready && o_out_last) |=> r_st == ST_IDLE && r_pos == '0)
        else $error("digest end did not return to idle");
`endif
endmodule
